@@ rtl/core/ptc_pkg.sv @@
package ptc_pkg;

  localparam int unsigned FEAT_COUNT     = 4;
  localparam int unsigned NUM_INPUTS_DEF = 4;

  localparam int unsigned FEAT_W   = 16;
  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned LR_W     = 16;

  localparam int unsigned PROD_W  = WEIGHT_W + FEAT_W;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned STEP_PW = LR_W + 1 + FEAT_W;
  localparam int unsigned RND_W   = STEP_PW + 1;
  localparam int unsigned FRAC_SH = 12;
  localparam int unsigned STEP_W  = RND_W - FRAC_SH;
  localparam int unsigned WIDE_W  = WEIGHT_W + 2;

  localparam logic [LR_W-1:0]  LR_RESET  = LR_W'(6554);
  localparam logic [SUM_W-1:0] ONE_Q28   = SUM_W'(64'd1 << 28);
  localparam logic [RND_W-1:0] RND_HALF  = RND_W'(64'd1 << (FRAC_SH - 1));

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_SUM  = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic sum_en;
    logic upd_en;
    logic lr_we;
  } cmd_t;

endpackage

@@ rtl/core/ptc_ctrl.sv @@
module ptc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  output ptc_pkg::cmd_t cmd_o
);

  ptc_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ptc_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.lr_we   = cfg_valid_i;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      ptc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ptc_pkg::S_MUL;
        end
      end
      ptc_pkg::S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ptc_pkg::S_SUM;
      end
      ptc_pkg::S_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = ptc_pkg::S_UPD;
      end
      ptc_pkg::S_UPD: begin
        // hold until the output register can take the beat
        if (out_free) begin
          cmd_o.upd_en = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ptc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ptc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/core/ptc_datapath.sv @@
module ptc_datapath #(
  parameter int unsigned NumInputs = ptc_pkg::NUM_INPUTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ptc_pkg::cmd_t                     cmd_i,
  input  logic [ptc_pkg::LR_W-1:0]          lr_data_i,
  input  logic                              op_i,
  input  logic                              expected_i,
  input  logic signed [ptc_pkg::FEAT_W-1:0] feature_i [ptc_pkg::FEAT_COUNT],
  output logic                              decision_o,
  output logic                              updated_o
);

  localparam int unsigned FW = ptc_pkg::FEAT_W;
  localparam int unsigned WW = ptc_pkg::WEIGHT_W;
  localparam int unsigned PW = ptc_pkg::PROD_W;
  localparam int unsigned SW = ptc_pkg::SUM_W;
  localparam int unsigned QW = ptc_pkg::STEP_PW;
  localparam int unsigned RW = ptc_pkg::RND_W;
  localparam int unsigned TW = ptc_pkg::STEP_W;
  localparam int unsigned XW = ptc_pkg::WIDE_W;

  logic [ptc_pkg::LR_W-1:0] lr_q;
  logic                     op_q, exp_q, dec_q;
  logic                     decision_q, updated_q;
  logic signed [FW-1:0]     feat_q [NumInputs];
  logic signed [WW-1:0]     w_q    [NumInputs];
  logic signed [WW-1:0]     w_d    [NumInputs];
  logic signed [PW-1:0]     prod_q [NumInputs];
  logic signed [QW-1:0]     stp_q  [NumInputs];
  logic signed [SW-1:0]     sum;
  logic                     train;

  assign train = op_q && (dec_q != exp_q);

  always_comb begin
    sum = '0;
    for (int i = 0; i < NumInputs; i++) begin
      sum = sum + $signed({{(SW-PW){prod_q[i][PW-1]}}, prod_q[i]});
    end
  end

  always_comb begin
    logic signed [RW-1:0] rnd;
    logic signed [TW-1:0] step;
    logic signed [XW-1:0] wide;
    rnd  = '0;
    step = '0;
    wide = '0;
    for (int i = 0; i < NumInputs; i++) begin
      rnd  = $signed({stp_q[i][QW-1], stp_q[i]}) + $signed(ptc_pkg::RND_HALF);
      step = rnd[RW-1:ptc_pkg::FRAC_SH];
      if (exp_q) begin
        wide = $signed({{(XW-WW){w_q[i][WW-1]}}, w_q[i]})
             + $signed({{(XW-TW){step[TW-1]}}, step});
      end else begin
        wide = $signed({{(XW-WW){w_q[i][WW-1]}}, w_q[i]})
             - $signed({{(XW-TW){step[TW-1]}}, step});
      end
      if (wide[XW-1:WW-1] == '0 || wide[XW-1:WW-1] == '1) begin
        w_d[i] = wide[WW-1:0];
      end else if (wide[XW-1]) begin
        w_d[i] = {1'b1, {(WW-1){1'b0}}};
      end else begin
        w_d[i] = {1'b0, {(WW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= ptc_pkg::LR_RESET;
      for (int i = 0; i < NumInputs; i++) begin
        w_q[i] <= '0;
      end
    end else begin
      if (cmd_i.lr_we) begin
        lr_q <= lr_data_i;
      end
      if (cmd_i.upd_en && train) begin
        for (int i = 0; i < NumInputs; i++) begin
          w_q[i] <= w_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_i;
      exp_q <= expected_i;
      for (int i = 0; i < NumInputs; i++) begin
        feat_q[i] <= feature_i[i];
      end
    end
    if (cmd_i.mul_en) begin
      for (int i = 0; i < NumInputs; i++) begin
        prod_q[i] <= w_q[i] * feat_q[i];
        stp_q[i]  <= $signed({1'b0, lr_q}) * feat_q[i];
      end
    end
    if (cmd_i.sum_en) begin
      dec_q <= (sum > $signed(ptc_pkg::ONE_Q28));
    end
    if (cmd_i.upd_en) begin
      decision_q <= dec_q;
      updated_q  <= train;
    end
  end

  assign decision_o = decision_q;
  assign updated_o  = updated_q;

endmodule

@@ rtl/core/perceptron_train_classify_top.sv @@
// Single-layer perceptron with on-line training. Each input beat carries four
// signed Q4.12 features, an expected class and an op bit; the block returns one
// output beat with the decision (weighted sum of the stored Q8.16 weights above
// 1.0) and a flag that tells whether the weights were trained on this sample.
// An item passes capture, one multiply per lane, the adder tree and compare,
// then the saturating weight update, which the next sample's multiply depends
// on. The block takes the next sample only once it is back in idle, after the
// update step. The result sits in an output register, so a new sample is taken
// while it waits; a second result holds in the update step until the first beat
// is taken. learning_rate is an unsigned Q0.16 value written through the config
// port; the user must write it only while the block is idle, which the block
// itself does not enforce.
module perceptron_train_classify_top #(
  parameter int unsigned NUM_INPUTS = ptc_pkg::NUM_INPUTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic signed [ptc_pkg::FEAT_W-1:0] feature_a_i,
  input  logic signed [ptc_pkg::FEAT_W-1:0] feature_b_i,
  input  logic signed [ptc_pkg::FEAT_W-1:0] feature_c_i,
  input  logic signed [ptc_pkg::FEAT_W-1:0] feature_d_i,
  input  logic                              expected_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              decision_o,
  output logic                              updated_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ptc_pkg::LR_W-1:0]          cfg_learning_rate_i
);

  ptc_pkg::cmd_t                     cmd;
  logic signed [ptc_pkg::FEAT_W-1:0] feat [ptc_pkg::FEAT_COUNT];

  assign feat[0] = feature_a_i;
  assign feat[1] = feature_b_i;
  assign feat[2] = feature_c_i;
  assign feat[3] = feature_d_i;

  ptc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  ptc_datapath #(
    .NumInputs (NUM_INPUTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .lr_data_i  (cfg_learning_rate_i),
    .op_i       (op_i),
    .expected_i (expected_i),
    .feature_i  (feat),
    .decision_o (decision_o),
    .updated_o  (updated_o)
  );

endmodule
